// ----- hdl/nna_pkg.sv -----
`default_nettype none
package nna_pkg;
   localparam int OperandWidthDefault = 16;
   localparam int OpWidth = 4;
   localparam int ValueWidth = 32;

   typedef enum logic [3:0] {
      OP_ISZERO  = 4'd0,
      OP_SUCC    = 4'd1,
      OP_ADD     = 4'd2,
      OP_EQUAL   = 4'd3,
      OP_GREATER = 4'd4,
      OP_SUB     = 4'd5,
      OP_MUL     = 4'd6,
      OP_DIV     = 4'd7,
      OP_MOD     = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

// ----- hdl/nna_div_cell.sv -----
`default_nettype none
// one restoring division step; the row of cells passes the partial remainder along
module nna_div_cell #(
   parameter int W = nna_pkg::OperandWidthDefault
) (
   input  wire logic         clock,
   input  wire logic         load,
   input  wire logic         step,
   input  wire logic [W-1:0] rem_left,
   input  wire logic [W-1:0] divisor,
   input  wire logic         dividend_bit,
   output logic      [W-1:0] rem_out,
   output logic              quot_bit
);
   logic [W-1:0] rem_ff, rem_in;
   logic         q_ff, q_in;
   logic [W:0]   trial;
   logic [W:0]   diff;

   always_comb begin
      trial = {rem_left, dividend_bit};
      diff  = trial - {1'b0, divisor};
      rem_in = rem_ff;
      q_in   = q_ff;
      if (load) begin
         rem_in = '0;
         q_in   = 1'b0;
      end else if (step) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            q_in   = 1'b1;
         end else begin
            rem_in = trial[W-1:0];
            q_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign rem_out  = rem_ff;
   assign quot_bit = q_ff;
endmodule
`default_nettype wire

// ----- hdl/nna_div_chain.sv -----
`default_nettype none
// row of W step cells; one cell fires per cycle, left to right, each reading its left neighbor
module nna_div_chain #(
   parameter int W = nna_pkg::OperandWidthDefault
) (
   input  wire logic         clock,
   input  wire logic         load,
   input  wire logic [W-1:0] fire,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic      [W-1:0] quotient,
   output logic      [W-1:0] remainder
);
   logic [W-1:0] rem [W+1];

   assign rem[0] = '0;

   for (genvar i = 0; i < W; i++) begin : g_cell
      nna_div_cell #(.W(W)) u_cell (
         .clock       (clock),
         .load        (load),
         .step        (fire[i]),
         .rem_left    (rem[i]),
         .divisor     (divisor),
         .dividend_bit(dividend[W-1-i]),
         .rem_out     (rem[i+1]),
         .quot_bit    (quotient[W-1-i])
      );
   end

   assign remainder = rem[W];
endmodule
`default_nettype wire

// ----- hdl/natural_number_alu_top.sv -----
`default_nettype none
// channel   ports                                         dir
// request   req_valid req_stall req_op req_operand_a/b   in
// response  rsp_valid rsp_stall rsp_value rsp_error       out
// one word at a time: div and mod run through the divider row (one cell of the
// divider row fires per cycle), other ops go through the result register.
// a new request word is taken once the previous response word has left.
// reset is synchronous and clears the valid flags and state; rsp_stall holds the word.
module natural_number_alu_top #(
   parameter int OPERAND_WIDTH = nna_pkg::OperandWidthDefault
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [nna_pkg::OpWidth-1:0]     req_op,
   input  wire logic [OPERAND_WIDTH-1:0]        req_operand_a,
   input  wire logic [OPERAND_WIDTH-1:0]        req_operand_b,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [nna_pkg::ValueWidth-1:0]       rsp_value,
   output logic                                 rsp_error
);
   localparam int W = OPERAND_WIDTH;
   localparam int VW = nna_pkg::ValueWidth;

   nna_pkg::state_type state_ff, state_in;
   logic [nna_pkg::OpWidth-1:0] op_ff, op_in;
   logic [W-1:0] a_ff, a_in, b_ff, b_in;
   logic [W-1:0] fire_ff, fire_in;
   logic [VW-1:0] value_ff, value_in;
   logic error_ff, error_in;
   logic accept, load;
   logic [W-1:0] quotient, remainder;
   logic [2*W-1:0] product;
   logic [W:0] sum;

   assign accept = req_valid && !req_stall;
   assign load = accept;
   assign product = a_ff * b_ff;
   assign sum = {1'b0, a_ff} + {1'b0, b_ff};

   nna_div_chain #(.W(W)) u_chain (
      .clock    (clock),
      .load     (load),
      .fire     (fire_ff),
      .dividend (a_ff),
      .divisor  (b_ff),
      .quotient (quotient),
      .remainder(remainder)
   );

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      a_in = a_ff;
      b_in = b_ff;
      fire_in = fire_ff;
      value_in = value_ff;
      error_in = error_ff;
      req_stall = (state_ff != nna_pkg::ST_IDLE);
      case (state_ff)
         nna_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in = req_op;
               a_in = req_operand_a;
               b_in = req_operand_b;
               fire_in = '0;
               fire_in[0] = 1'b1;
               state_in = nna_pkg::ST_RUN;
            end
         end
         nna_pkg::ST_RUN: begin
            fire_in = fire_ff << 1;
            if (op_ff != nna_pkg::OP_DIV && op_ff != nna_pkg::OP_MOD ||
                b_ff == '0 || fire_ff == '0) begin
               fire_in = '0;
               state_in = nna_pkg::ST_DONE;
               value_in = '0;
               error_in = 1'b0;
               case (op_ff)
                  nna_pkg::OP_ISZERO:  value_in = VW'(a_ff == '0);
                  nna_pkg::OP_SUCC:    value_in = VW'({1'b0, a_ff} + (W+1)'(1));
                  nna_pkg::OP_ADD:     value_in = VW'(sum);
                  nna_pkg::OP_EQUAL:   value_in = VW'(a_ff == b_ff);
                  nna_pkg::OP_GREATER: value_in = VW'(a_ff > b_ff);
                  nna_pkg::OP_SUB: begin
                     if (a_ff < b_ff) error_in = 1'b1;
                     else value_in = VW'(a_ff - b_ff);
                  end
                  nna_pkg::OP_MUL:     value_in = VW'(product);
                  nna_pkg::OP_DIV: begin
                     if (b_ff == '0) error_in = 1'b1;
                     else value_in = VW'(quotient);
                  end
                  nna_pkg::OP_MOD: begin
                     if (b_ff == '0) error_in = 1'b1;
                     else value_in = VW'(remainder);
                  end
                  default: error_in = 1'b1;
               endcase
            end
         end
         nna_pkg::ST_DONE: begin
            if (!rsp_stall) state_in = nna_pkg::ST_IDLE;
         end
         default: state_in = nna_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nna_pkg::ST_IDLE;
         fire_ff <= '0;
      end else begin
         state_ff <= state_in;
         fire_ff <= fire_in;
      end
      op_ff <= op_in;
      a_ff <= a_in;
      b_ff <= b_in;
      value_ff <= value_in;
      error_ff <= error_in;
   end

   assign rsp_valid = (state_ff == nna_pkg::ST_DONE);
   assign rsp_value = value_ff;
   assign rsp_error = error_ff;
endmodule
`default_nettype wire
